@@ src/wfds_pkg.sv @@
// wfds_pkg: shared types, constants and elaboration-time table builders
// for the windowed dB spectrum core. No dependencies.
`default_nettype none

package wfds_pkg;

   localparam int TAB_DEPTH = 64;
   localparam int RE_W      = 25;
   localparam int ACC_W     = 40;
   localparam int PW_W      = 50;
   localparam int DB_W      = 26;
   localparam int NUM_W     = 28;
   localparam int FRAC_W    = 16;

   localparam logic [31:0]            DB_PER_LOG2 = 32'd197283;
   localparam logic signed [DB_W-1:0] DB_FLOOR    = -26'sd7188709;
   localparam logic signed [NUM_W-1:0] RANGE_Q16  = 28'sd3932160;
   localparam logic signed [NUM_W-1:0] DIV_BIAS   = 28'sd30;
   localparam logic [31:0]            RECIP_60    = 32'd4473925;
   localparam logic [63:0]            DB_ROUND    = 64'd32768;
   localparam longint                 CORDIC_GAIN = 64'sd326016437;
   localparam longint                 TURN_SCALE  = 64'sd3373259426;

   localparam longint ATAN_Q29 [16] = '{
      64'sd421657428, 64'sd248918915, 64'sd131521918, 64'sd66762579,
      64'sd33510843, 64'sd16771758, 64'sd8387925, 64'sd4194219,
      64'sd2097141, 64'sd1048575, 64'sd524288, 64'sd262144,
      64'sd131072, 64'sd65536, 64'sd32768, 64'sd16384
   };

   typedef logic [TAB_DEPTH-1:0][15:0] trig_tab_type;
   typedef logic [TAB_DEPTH-1:0][16:0] hann_tab_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_BIN_START, ST_BIN_WAIT, ST_SQ_RE, ST_SQ_IM, ST_SQ_SUM,
      ST_NORM, ST_LOG_MUL, ST_LOG_ACC, ST_DB_MUL, ST_DB_ACC, ST_STORE,
      ST_LVL_RD, ST_LVL_NUM, ST_LVL_Q, ST_OUT
   } state_type;

   typedef struct packed {
      logic       start;
      logic       win_en;
      logic       full;
      logic [6:0] count;
      logic [5:0] ptr;
      logic [5:0] k;
   } dft_ctrl_type;

   typedef struct packed {
      logic                   done;
      logic signed [RE_W-1:0] re;
      logic signed [RE_W-1:0] im;
   } dft_stat_type;

   function automatic logic [15:0] to_q15(input longint v);
      longint r;
      r = (v + 64'sd8192) >>> 14;
      if (r > 64'sd32767) r = 64'sd32767;
      if (r < -64'sd32768) r = -64'sd32768;
      return r[15:0];
   endfunction

   // returns {cos, sin} in q1.15
   function automatic logic [31:0] cordic_turn(input logic [31:0] phase);
      longint x;
      longint y;
      longint z;
      longint t;
      longint r;
      logic [15:0] c;
      logic [15:0] s;
      r = longint'({34'd0, phase[29:0]});
      z = (r * TURN_SCALE) >>> 32;
      x = CORDIC_GAIN;
      y = 64'sd0;
      for (int k = 0; k < 16; k++) begin
         if (z >= 0) begin
            t = x - (y >>> k); y = y + (x >>> k); x = t; z = z - ATAN_Q29[k];
         end else begin
            t = x + (y >>> k); y = y - (x >>> k); x = t; z = z + ATAN_Q29[k];
         end
      end
      case (phase[31:30])
         2'd0: begin c = to_q15(x);  s = to_q15(y);  end
         2'd1: begin c = to_q15(-y); s = to_q15(x);  end
         2'd2: begin c = to_q15(-x); s = to_q15(-y); end
         default: begin c = to_q15(y); s = to_q15(-x); end
      endcase
      return {c, s};
   endfunction

   // floor(i * 2^32 / period) mod 2^32, shift-subtract
   function automatic logic [31:0] phase_of(input int i, input int period);
      longint num;
      longint rem;
      logic [31:0] q;
      num = longint'(i) <<< 32;
      rem = 64'sd0;
      q = '0;
      for (int b = 39; b >= 0; b--) begin
         rem = (rem <<< 1) | longint'({63'd0, num[b]});
         if (rem >= longint'(period)) begin
            rem = rem - longint'(period);
            if (b < 32) q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic hann_tab_type build_hann(input int size);
      hann_tab_type t;
      logic [31:0] cs;
      t = '0;
      for (int i = 0; i < TAB_DEPTH; i++) begin
         if (i < size) begin
            cs = cordic_turn(phase_of(i, size - 1));
            t[i] = 17'(32'sd32768 - 32'($signed(cs[31:16])));
         end
      end
      return t;
   endfunction

   function automatic trig_tab_type build_trig(input int size, input logic want_sin);
      trig_tab_type t;
      logic [31:0] cs;
      t = '0;
      for (int i = 0; i < TAB_DEPTH; i++) begin
         if (i < size) begin
            cs = cordic_turn(phase_of(i, size));
            t[i] = want_sin ? cs[15:0] : cs[31:16];
         end
      end
      return t;
   endfunction

endpackage

`default_nettype wire

@@ src/wfds_mul.sv @@
// wfds_mul: the shared 32x32 unsigned multiplier with a registered product.
// Depends on nothing.
`default_nettype none

module wfds_mul (
   input  wire logic        clock,
   input  wire logic [31:0] a,
   input  wire logic [31:0] b,
   output logic [63:0]      p
);
   logic [63:0] p_ff;

   always_ff @(posedge clock) begin
      p_ff <= 64'(a) * 64'(b);
   end

   assign p = p_ff;

endmodule

`default_nettype wire

@@ src/wfds_dft.sv @@
// wfds_dft: sample ring memory, hann window and one-bin dft accumulator.
// One bin reads FFT_SIZE ring samples in turn, then drains a four-stage tail. Uses wfds_pkg.
`default_nettype none

module wfds_dft #(
   parameter int FFT_SIZE = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire logic signed [15:0]  wr_data,
   input  wire wfds_pkg::dft_ctrl_type ctrl,
   output wfds_pkg::dft_stat_type   stat
);
   import wfds_pkg::*;

   localparam int IDX_W = $clog2(FFT_SIZE);
   localparam int CNT_W = $clog2(FFT_SIZE + 1);
   localparam hann_tab_type HANN_TAB = build_hann(FFT_SIZE);
   localparam trig_tab_type COS_TAB  = build_trig(FFT_SIZE, 1'b0);
   localparam trig_tab_type SIN_TAB  = build_trig(FFT_SIZE, 1'b1);

   logic signed [15:0] ring_mem [FFT_SIZE];
   logic signed [15:0] rd_data_ff;

   logic             run_ff, run_in;
   logic [IDX_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] tw_ff, tw_in;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W:0]   addr_sum, tw_sum;
   logic             last_issue, mask0;

   logic             v1_ff, first1_ff, last1_ff, mask1_ff;
   logic [IDX_W-1:0] n1_ff, tw1_ff;
   logic             v2_ff, first2_ff, last2_ff;
   logic [IDX_W-1:0] tw2_ff;
   logic signed [15:0] x2_ff;
   logic signed [33:0] wprod2_ff;
   logic             v3_ff, first3_ff, last3_ff;
   logic signed [31:0] pc3_ff, ps3_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff, sum_re, sum_im;
   logic             done_ff;

   logic signed [15:0] x1, xw;
   logic [16:0]        hann_w;
   logic signed [33:0] wprod_in, wsum;

   assign last_issue = (n_ff == IDX_W'(FFT_SIZE - 1));
   assign addr_sum   = {1'b0, ctrl.ptr[IDX_W-1:0]} + {1'b0, n_ff};
   assign tw_sum     = {1'b0, tw_ff} + {1'b0, ctrl.k[IDX_W-1:0]};

   always_comb begin
      if (!ctrl.full) begin
         rd_addr = n_ff;
      end else if (addr_sum >= (IDX_W + 1)'(FFT_SIZE)) begin
         rd_addr = IDX_W'(addr_sum - (IDX_W + 1)'(FFT_SIZE));
      end else begin
         rd_addr = IDX_W'(addr_sum);
      end
      // short frame: unfilled positions read as zero
      mask0 = ctrl.full || (CNT_W'(n_ff) < ctrl.count[CNT_W-1:0]);
   end

   always_comb begin
      run_in = run_ff;
      n_in   = n_ff;
      tw_in  = tw_ff;
      if (ctrl.start) begin
         run_in = 1'b1;
         n_in   = '0;
         tw_in  = '0;
      end else if (run_ff) begin
         if (last_issue) run_in = 1'b0;
         n_in = n_ff + 1'b1;
         if (tw_sum >= (IDX_W + 1)'(FFT_SIZE)) begin
            tw_in = IDX_W'(tw_sum - (IDX_W + 1)'(FFT_SIZE));
         end else begin
            tw_in = IDX_W'(tw_sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[ctrl.ptr[IDX_W-1:0]] <= wr_data;
      end
      rd_data_ff <= ring_mem[rd_addr];
   end

   // stage 1: window product
   always_comb begin
      x1       = mask1_ff ? rd_data_ff : 16'sd0;
      hann_w   = HANN_TAB[6'(n1_ff)];
      wprod_in = 34'(x1) * $signed({17'd0, hann_w});
   end

   // stage 2: rounded windowed sample (raw sample with the window off) times twiddles
   assign wsum = wprod2_ff + 34'sd32768;
   assign xw   = ctrl.win_en ? wsum[31:16] : x2_ff;

   assign sum_re = acc_re_ff + ACC_W'(16384);
   assign sum_im = acc_im_ff + ACC_W'(16384);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         v1_ff   <= run_ff;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         done_ff <= v3_ff && last3_ff;
      end
      n_ff      <= n_in;
      tw_ff     <= tw_in;
      first1_ff <= (n_ff == '0);
      last1_ff  <= last_issue;
      mask1_ff  <= mask0;
      n1_ff     <= n_ff;
      tw1_ff    <= tw_ff;
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      tw2_ff    <= tw1_ff;
      x2_ff     <= x1;
      wprod2_ff <= wprod_in;
      first3_ff <= first2_ff;
      last3_ff  <= last2_ff;
      pc3_ff    <= 32'(xw) * 32'($signed(COS_TAB[6'(tw2_ff)]));
      ps3_ff    <= 32'(xw) * 32'($signed(SIN_TAB[6'(tw2_ff)]));
      if (v3_ff) begin
         acc_re_ff <= (first3_ff ? ACC_W'(0) : acc_re_ff) + ACC_W'(pc3_ff);
         acc_im_ff <= (first3_ff ? ACC_W'(0) : acc_im_ff) - ACC_W'(ps3_ff);
      end
   end

   assign stat.done = done_ff;
   assign stat.re   = sum_re[ACC_W-1:15];
   assign stat.im   = sum_im[ACC_W-1:15];

endmodule

`default_nettype wire

@@ src/windowed_fft_db_spectrum_core.sv @@
// windowed_fft_db_spectrum_core: hann-windowed dft magnitude spectrum in dB.
// Uses wfds_pkg, wfds_dft (per-bin accumulator) and wfds_mul (shared multiplier).
//
// Usage: samples enter on the req_ channel one beat each; req_frame_last marks
// the final sample of a frame and starts the transform. While the transform
// runs req_stall is high. Bins 0 to FFT_SIZE/2 then leave on the rsp_ channel,
// one beat each, rsp_spectrum_last on the final bin. csr_wr_en with csr_wr_data
// sets window enable (reset value 1); write it only while the block is idle.
// Sequence: a sample without frame_last is only written to the ring. A flagged
// sample is also written and then, per bin, runs the dft accumulator, squaring on
// the shared multiplier, a leading-one search, log2 squaring and a scale-and-store
// step (a zero bin skips the log2 steps); each output beat then passes the level
// read, the level numerator, a quotient step for a positive numerator and the
// output step. The dft loop (one product pair per cycle) and the log2 squaring
// loop dominate.
// Reset: synchronous; clears the sample pointer, frame count and sequencer.
// A stalled rsp beat holds the sequencer in its output step until taken.
`default_nettype none

module windowed_fft_db_spectrum_core #(
   parameter int FFT_SIZE = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_sample,
   input  wire logic               req_frame_last,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [5:0]              rsp_bin_index,
   output logic [15:0]             rsp_level,
   output logic                    rsp_spectrum_last,
   input  wire logic               csr_wr_en,
   input  wire logic               csr_wr_data
);
   import wfds_pkg::*;

   localparam int IDX_W     = $clog2(FFT_SIZE);
   localparam int CNT_W     = $clog2(FFT_SIZE + 1);
   localparam int HALF_BINS = FFT_SIZE / 2 + 1;
   localparam int BIN_W     = $clog2(HALF_BINS);

   state_type state_ff, state_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             win_en_ff;
   logic [BIN_W-1:0] k_ff, k_in;
   logic [RE_W-1:0]  re_abs_ff, re_abs_in, im_abs_ff, im_abs_in;
   logic [PW_W-1:0]  pw_ff, pw_in;
   logic [5:0]       e_ff, e_in;
   logic [31:0]      m_ff, m_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [3:0]       lcnt_ff, lcnt_in;
   logic signed [DB_W-1:0] db_ff, db_in, peak_ff, peak_in, rd_ff;
   logic [15:0]      lvl_ff, lvl_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [5:0]       bin_index_ff, bin_index_in;
   logic [15:0]      level_ff, level_in;
   logic             last_ff, last_in;

   logic signed [DB_W-1:0] db_mem [HALF_BINS];

   logic         accept, last_bin, out_free;
   logic [31:0]  mul_a, mul_b;
   logic [63:0]  mul_p;
   logic [63:0]  db_sum;
   logic signed [NUM_W-1:0] num;
   dft_ctrl_type dft_ctrl;
   dft_stat_type dft_stat;

   assign accept    = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign last_bin  = (k_ff == BIN_W'(HALF_BINS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign db_sum    = mul_p + DB_ROUND;
   assign num       = NUM_W'(rd_ff) - NUM_W'(peak_ff) + RANGE_Q16;

   assign dft_ctrl.start  = (state_ff == ST_BIN_START);
   assign dft_ctrl.win_en = win_en_ff;
   assign dft_ctrl.full   = (count_ff == CNT_W'(FFT_SIZE));
   assign dft_ctrl.count  = 7'(count_ff);
   assign dft_ctrl.ptr    = 6'(ptr_ff);
   assign dft_ctrl.k      = 6'(k_ff);

   wfds_dft #(.FFT_SIZE(FFT_SIZE)) u_dft (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (req_sample),
      .ctrl    (dft_ctrl),
      .stat    (dft_stat)
   );

   wfds_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      re_abs_in    = re_abs_ff;
      im_abs_in    = im_abs_ff;
      pw_in        = pw_ff;
      e_in         = e_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      lcnt_in      = lcnt_ff;
      db_in        = db_ff;
      peak_in      = peak_ff;
      lvl_in       = lvl_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      bin_index_in = bin_index_ff;
      level_in     = level_ff;
      last_in      = last_ff;
      mul_a        = '0;
      mul_b        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ptr_in = (ptr_ff == IDX_W'(FFT_SIZE - 1)) ? '0 : ptr_ff + 1'b1;
               if (count_ff != CNT_W'(FFT_SIZE)) count_in = count_ff + 1'b1;
               if (req_frame_last) begin
                  k_in     = '0;
                  peak_in  = DB_FLOOR;
                  state_in = ST_BIN_START;
               end
            end
         end
         ST_BIN_START: state_in = ST_BIN_WAIT;
         ST_BIN_WAIT: begin
            if (dft_stat.done) begin
               re_abs_in = dft_stat.re[RE_W-1] ? RE_W'(-dft_stat.re) : RE_W'(dft_stat.re);
               im_abs_in = dft_stat.im[RE_W-1] ? RE_W'(-dft_stat.im) : RE_W'(dft_stat.im);
               state_in  = ST_SQ_RE;
            end
         end
         ST_SQ_RE: begin
            mul_a    = 32'(re_abs_ff);
            mul_b    = 32'(re_abs_ff);
            state_in = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            mul_a    = 32'(im_abs_ff);
            mul_b    = 32'(im_abs_ff);
            pw_in    = mul_p[PW_W-1:0];
            state_in = ST_SQ_SUM;
         end
         ST_SQ_SUM: begin
            pw_in    = pw_ff + mul_p[PW_W-1:0];
            e_in     = 6'(PW_W - 1);
            state_in = ST_NORM;
         end
         ST_NORM: begin
            // leading-one search, eight places at a time while the top byte is clear
            if (pw_ff == '0) begin
               db_in    = DB_FLOOR;
               state_in = ST_STORE;
            end else if (pw_ff[PW_W-1]) begin
               m_in     = pw_ff[PW_W-1 -: 32];
               frac_in  = '0;
               lcnt_in  = '0;
               state_in = ST_LOG_MUL;
            end else if (pw_ff[PW_W-1 -: 8] == 8'd0) begin
               pw_in = pw_ff << 8;
               e_in  = e_ff - 6'd8;
            end else begin
               pw_in = pw_ff << 1;
               e_in  = e_ff - 6'd1;
            end
         end
         ST_LOG_MUL: begin
            mul_a    = m_ff;
            mul_b    = m_ff;
            state_in = ST_LOG_ACC;
         end
         ST_LOG_ACC: begin
            frac_in  = {frac_ff[FRAC_W-2:0], mul_p[63]};
            m_in     = mul_p[63] ? mul_p[63:32] : mul_p[62:31];
            lcnt_in  = lcnt_ff + 1'b1;
            state_in = (lcnt_ff == 4'd15) ? ST_DB_MUL : ST_LOG_MUL;
         end
         ST_DB_MUL: begin
            mul_a    = 32'({e_ff, frac_ff});
            mul_b    = DB_PER_LOG2;
            state_in = ST_DB_ACC;
         end
         ST_DB_ACC: begin
            db_in    = db_sum[16 +: DB_W];
            state_in = ST_STORE;
         end
         ST_STORE: begin
            if (db_ff > peak_ff) peak_in = db_ff;
            if (last_bin) begin
               k_in     = '0;
               state_in = ST_LVL_RD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_BIN_START;
            end
         end
         ST_LVL_RD: state_in = ST_LVL_NUM;
         ST_LVL_NUM: begin
            if (num > 28'sd0) begin
               // divide by 60 through a reciprocal, exact below 2^22
               mul_a    = 32'(num + DIV_BIAS);
               mul_b    = RECIP_60;
               state_in = ST_LVL_Q;
            end else begin
               lvl_in   = '0;
               state_in = ST_OUT;
            end
         end
         ST_LVL_Q: begin
            lvl_in   = (mul_p[63:44] != '0) ? 16'hFFFF : mul_p[43:28];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               bin_index_in = 6'(k_ff);
               level_in     = lvl_ff;
               last_in      = last_bin;
               if (last_bin) begin
                  k_in     = '0;
                  ptr_in   = '0;
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_LVL_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         count_ff     <= '0;
         k_ff         <= '0;
         peak_ff      <= '0;
         win_en_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) win_en_ff <= csr_wr_data;
      end
      re_abs_ff    <= re_abs_in;
      im_abs_ff    <= im_abs_in;
      pw_ff        <= pw_in;
      e_ff         <= e_in;
      m_ff         <= m_in;
      frac_ff      <= frac_in;
      lcnt_ff      <= lcnt_in;
      db_ff        <= db_in;
      lvl_ff       <= lvl_in;
      bin_index_ff <= bin_index_in;
      level_ff     <= level_in;
      last_ff      <= last_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_STORE) begin
         db_mem[k_ff] <= db_ff;
      end
      rd_ff <= db_mem[k_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bin_index     = bin_index_ff;
   assign rsp_level         = level_ff;
   assign rsp_spectrum_last = last_ff;

   // the accumulator only finishes a bin while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      dft_stat.done |-> state_ff == ST_BIN_WAIT)
      else $error("dft result outside wait step");

   // stored level never lies above the running peak
   a_peak_tracks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STORE |=> peak_ff >= $past(db_ff))
      else $error("peak below a stored bin");

   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      k_ff <= BIN_W'(HALF_BINS - 1))
      else $error("bin counter out of range");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FFT_SIZE))
      else $error("frame count beyond ring depth");

endmodule

`default_nettype wire

@@ test/windowed_fft_db_spectrum_core_test.sv @@
// windowed_fft_db_spectrum_core_test: self-checking bench for the dB spectrum core.
// Depends on windowed_fft_db_spectrum_core; keeps its own bit-exact spectrum predictor
// and compares every rsp beat against it, with random idling on both channels.
`timescale 1ns / 1ps

module windowed_fft_db_spectrum_core_test;

   localparam int N         = 64;
   localparam int BINS      = N / 2 + 1;
   localparam int IDLE_MAX  = 50000;
   localparam int DB_FLOOR  = -7188709;
   localparam int DB_RANGE  = 3932160;

   typedef struct {
      logic signed [15:0] sample;
      logic               last;
   } sample_beat_type;

   typedef struct {
      logic [5:0]  bin;
      logic [15:0] level;
      logic        last;
   } bin_beat_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_sample = '0;
   logic               req_frame_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [5:0]         rsp_bin_index;
   logic [15:0]        rsp_level;
   logic               rsp_spectrum_last;
   logic               csr_wr_en = 1'b0;
   logic               csr_wr_data = 1'b0;

   sample_beat_type pending_samples[$];
   bin_beat_type    expected_bins[$];
   sample_beat_type current_beat;

   longint atan_tab [16] = '{
      421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
      8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
      32768, 16384
   };

   int    hann_w [N];
   int    cos_tab [N];
   int    sin_tab [N];
   int    ring [N];
   int    ring_ptr = 0;
   int    ring_count = 0;
   bit    window_on = 1'b1;

   int    errors = 0;
   int    idle_cycles = 0;
   int    req_gap = 0;
   int    rsp_gap = 0;
   bit    calm = 1'b0;

   windowed_fft_db_spectrum_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sample(req_sample), .req_frame_last(req_frame_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_bin_index(rsp_bin_index), .rsp_level(rsp_level),
      .rsp_spectrum_last(rsp_spectrum_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int sat_q15(input longint v);
      longint r;
      r = (v + 64'sd8192) >>> 14;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return int'(r);
   endfunction

   task automatic rotate(input logic [31:0] phase, output int c, output int s);
      longint x, y, z, t, r;
      r = longint'({34'd0, phase[29:0]});
      z = (r * 64'sd3373259426) >>> 32;
      x = 64'sd326016437;
      y = 0;
      for (int k = 0; k < 16; k++) begin
         if (z >= 0) begin
            t = x - (y >>> k); y = y + (x >>> k); x = t; z = z - atan_tab[k];
         end else begin
            t = x + (y >>> k); y = y - (x >>> k); x = t; z = z + atan_tab[k];
         end
      end
      case (phase[31:30])
         2'd0: begin c = sat_q15(x); s = sat_q15(y); end
         2'd1: begin c = sat_q15(-y); s = sat_q15(x); end
         2'd2: begin c = sat_q15(-x); s = sat_q15(-y); end
         default: begin c = sat_q15(y); s = sat_q15(-x); end
      endcase
   endtask

   function automatic int power_db(input logic [63:0] p);
      int          e;
      logic [15:0] frac;
      logic [63:0] m;
      logic [63:0] lg;
      if (p == 0) return DB_FLOOR;
      e = 0;
      while (e < 63 && (p >> (e + 1)) != 0) e++;
      m = (e <= 31) ? (p << (31 - e)) : (p >> (e - 31));
      frac = '0;
      for (int k = 0; k < 16; k++) begin
         m = m * m;
         frac = frac << 1;
         if (m[63]) begin
            frac[0] = 1'b1;
            m = m >> 32;
         end else begin
            m = m >> 31;
         end
      end
      lg = (64'(e) << 16) | 64'(frac);
      lg = (lg * 64'd197283 + 64'd32768) >> 16;
      return int'(lg);
   endfunction

   // runs on every accepted req beat
   task automatic absorb_sample(input sample_beat_type b);
      int          x [N];
      int          db [BINS];
      int          peak, idx;
      longint      re, im, num, lvl;
      logic [63:0] pw;
      bin_beat_type r;
      ring[ring_ptr] = int'(b.sample);
      ring_ptr = (ring_ptr + 1 >= N) ? 0 : ring_ptr + 1;
      if (ring_count < N) ring_count++;
      if (!b.last) return;
      for (int n = 0; n < N; n++) begin
         if (ring_count < N) x[n] = (n < ring_count) ? ring[n] : 0;
         else x[n] = ring[(ring_ptr + n) % N];
         if (window_on)
            x[n] = int'((longint'(x[n]) * longint'(hann_w[n]) + 64'sd32768) >>> 16);
      end
      peak = DB_FLOOR;
      for (int k = 0; k < BINS; k++) begin
         re = 0;
         im = 0;
         idx = 0;
         for (int n = 0; n < N; n++) begin
            re += longint'(x[n]) * cos_tab[idx];
            im -= longint'(x[n]) * sin_tab[idx];
            idx += k;
            if (idx >= N) idx -= N;
         end
         re = (re + 16384) >>> 15;
         im = (im + 16384) >>> 15;
         pw = 64'(re * re) + 64'(im * im);
         db[k] = power_db(pw);
         if (db[k] > peak) peak = db[k];
      end
      for (int k = 0; k < BINS; k++) begin
         num = longint'(db[k]) - peak + DB_RANGE;
         lvl = 0;
         if (num > 0) begin
            lvl = (num + 30) / 60;
            if (lvl > 65535) lvl = 65535;
         end
         r.bin = 6'(k);
         r.level = 16'(lvl);
         r.last = (k == BINS - 1);
         expected_bins.insert(expected_bins.size(), r);
      end
      ring_ptr = 0;
      ring_count = 0;
   endtask

   // req driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_stall) begin
            // stalled beat holds
         end else begin
            if (req_valid) absorb_sample(current_beat);
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               current_beat = pending_samples.pop_front();
               req_sample <= current_beat.sample;
               req_frame_last <= current_beat.last;
               req_valid <= 1'b1;
               if (!calm && $urandom_range(0, 5) == 0) req_gap = $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // rsp monitor and stall generator
   always @(posedge clock) begin
      bin_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bins.size() == 0) begin
            $display("%0t unexpected bin beat: bin %0d level %0d last %0b", $time,
                     rsp_bin_index, rsp_level, rsp_spectrum_last);
            errors++;
         end else begin
            e = expected_bins.pop_front();
            if (rsp_bin_index !== e.bin) begin
               $display("%0t bin_index expected %0d actual %0d", $time, e.bin, rsp_bin_index);
               errors++;
            end
            if (rsp_level !== e.level) begin
               $display("%0t level (bin %0d) expected %0d actual %0d", $time, e.bin,
                        e.level, rsp_level);
               errors++;
            end
            if (rsp_spectrum_last !== e.last) begin
               $display("%0t spectrum_last (bin %0d) expected %0b actual %0b", $time, e.bin,
                        e.last, rsp_spectrum_last);
               errors++;
            end
         end
      end
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm && $urandom_range(0, 5) == 0) rsp_gap = $urandom_range(1, 10);
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_MAX) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic add_beat(input logic signed [15:0] s, input logic l);
      sample_beat_type b;
      b.sample = s;
      b.last = l;
      pending_samples.insert(pending_samples.size(), b);
   endtask

   task automatic drain;
      while (pending_samples.size() > 0 || req_valid || expected_bins.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_window(input bit on);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= on;
      window_on = on;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [15:0] rand_sample;
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'(int'($urandom_range(0, 15)) - 8);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic add_random_frame(input int len);
      for (int i = 0; i < len; i++) add_beat(rand_sample(), i == len - 1);
   endtask

   initial begin
      int c, s, total, len;
      for (int i = 0; i < N; i++) begin
         rotate(32'((longint'(i) << 32) / (N - 1)), c, s);
         hann_w[i] = 32768 - c;
         rotate(32'((longint'(i) << 32) / N), c, s);
         cos_tab[i] = c;
         sin_tab[i] = s;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset value of the window register applies here
      add_beat(16'sd0, 1'b1);
      add_beat(16'sh7fff, 1'b0);
      add_beat(16'sh8000, 1'b0);
      add_beat(16'sh7fff, 1'b1);
      add_beat(16'sd1, 1'b0);
      add_beat(-16'sd1, 1'b0);
      add_beat(16'sh5555, 1'b0);
      add_beat(16'shaaaa, 1'b1);
      drain();
      set_window(1'b0);
      add_beat(16'sh8000, 1'b1);
      add_beat(16'sd0, 1'b0);
      add_beat(16'sd0, 1'b1);
      for (int i = 0; i < 6; i++) add_beat((i % 2) ? 16'sh8000 : 16'sh7fff, i == 5);
      drain();

      total = 0;
      for (int ph = 0; total < 330; ph++) begin
         set_window(ph % 2 == 0);
         calm = (total > 270);
         for (int f = 0; f < 4; f++) begin
            if ($urandom_range(0, 6) == 0) len = $urandom_range(60, 72);
            else len = $urandom_range(1, 14);
            add_random_frame(len);
            total += len;
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (errors == 0 && expected_bins.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         if (expected_bins.size() > 0)
            $display("%0t %0d expected bin beats never arrived", $time, expected_bins.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/wfds_pkg.sv
src/wfds_mul.sv
src/wfds_dft.sv
src/windowed_fft_db_spectrum_core.sv
test/windowed_fft_db_spectrum_core_test.sv
